### rtl/srrw_pkg.sv
// Shared types and constants for the selective-repeat receive window.
// Depends on nothing; imported by selective_repeat_receive_window.
package srrw_pkg;

    // Request codes carried by req_type.
    typedef enum logic [1:0] {
        REQ_ARRIVE  = 2'd0,
        REQ_TAKE    = 2'd1,
        REQ_ACK     = 2'd2,
        REQ_RESTART = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_STORED     = 3'd0,
        STAT_OUT_OF_WIN = 3'd1,
        STAT_DUPLICATE  = 3'd2,
        STAT_DELIVERED  = 3'd3,
        STAT_NONE_READY = 3'd4,
        STAT_ACK        = 3'd5,
        STAT_RESTARTED  = 3'd6
    } status_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SEQ_BITS    = 2'd0,
        CFG_WINDOW_SIZE = 2'd1,
        CFG_FULL_LEN    = 2'd2
    } cfg_index_t;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_COUNT = 3'b100
    } state_t;

    localparam int CFG_DATA_W = 16;
    localparam int SEQ_BITS_W = 5;
    localparam int WIN_SIZE_W = 6;
    localparam int FULL_LEN_W = 16;
    localparam int LEN_W      = 16;

    localparam logic [SEQ_BITS_W-1:0] SEQ_BITS_RESET = 5'd8;
    localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RESET = 6'd32;
    localparam logic [FULL_LEN_W-1:0] FULL_LEN_RESET = 16'd5120;

endpackage

### rtl/selective_repeat_receive_window.sv
// Selective-repeat receive window: sequencer, slot valid bits and handle memory.
// Depends on srrw_pkg for request, status, register and state codes.

// A request is taken when start is high and busy is low. Each request yields
// exactly one result, shown on the result ports for a single cycle while
// result_valid is high; the receiver cannot stall, so it must capture the
// result in that cycle. A new request can be taken while the previous one
// is in its count state: in the execute state after acceptance the request
// is applied to the slot state using the head handle read from the
// synchronous handle memory at acceptance, and in the count state the
// ready-count encoder runs over the updated valid bits. busy is high only
// in the execute state. Configuration registers may be written at any time
// but must only change while no request is in flight. The handle memory is
// not cleared by reset or restart; a slot's handle is used only after an
// arrival has stored it.
module selective_repeat_receive_window #(
    parameter int WINDOW_DEPTH = 32,
    parameter int SEQ_WIDTH    = 16,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  srrw_pkg::cfg_index_t                  cfg_index,
    input  logic [srrw_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Request side.
    input  logic                                  start,
    output logic                                  busy,
    input  srrw_pkg::req_t                        req_type,
    input  logic [SEQ_WIDTH-1:0]                  seq_num,
    input  logic [HANDLE_WIDTH-1:0]               payload_handle,
    input  logic [srrw_pkg::LEN_W-1:0]            chunk_length,
    // Result side.
    output logic                                  result_valid,
    output srrw_pkg::status_t                     status,
    output logic [HANDLE_WIDTH-1:0]               out_handle,
    output logic [SEQ_WIDTH-1:0]                  ack_num,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]     ready_count,
    output logic                                  done_flag
);
    import srrw_pkg::*;

    localparam int HW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int AW    = (SEQ_WIDTH > CNT_W) ? SEQ_WIDTH : CNT_W;
    localparam int BW    = 6;

    // Configuration registers.
    logic [SEQ_BITS_W-1:0]   seq_bits_reg;
    logic [WIN_SIZE_W-1:0]   win_size_reg;
    logic [FULL_LEN_W-1:0]   full_len_reg;

    // Sequencer and latched request.
    state_t                  state_reg, state_next;
    req_t                    req_reg;
    logic [SEQ_WIDTH-1:0]    seq_reg;
    logic [HANDLE_WIDTH-1:0] handle_reg;
    logic [LEN_W-1:0]        len_reg;

    // Window state.
    logic [SEQ_WIDTH-1:0]    base_reg, base_next;
    logic [HW-1:0]           head_reg, head_next;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic                    complete_reg, complete_next;

    // Pending result from the execute cycle.
    status_t                 stat_pend_reg, stat_pend_next;
    logic [HANDLE_WIDTH-1:0] oh_pend_reg, oh_pend_next;

    // Result registers.
    logic                    res_valid_reg;
    status_t                 status_reg;
    logic [HANDLE_WIDTH-1:0] out_handle_reg;
    logic [SEQ_WIDTH-1:0]    ack_reg;
    logic [CNT_W-1:0]        ready_reg;
    logic                    done_reg;

    // Handle memory.
    logic [HANDLE_WIDTH-1:0] handle_mem [WINDOW_DEPTH];
    logic [HANDLE_WIDTH-1:0] mem_rd_reg;
    logic                    mem_we;
    logic [HW-1:0]           mem_addr;

    logic                    accept;
    logic [BW-1:0]           eff_bits;
    logic [SEQ_WIDTH-1:0]    mmask;
    logic [CNT_W-1:0]        eff_win;
    logic [SEQ_WIDTH-1:0]    base_cur;
    logic [CNT_W-1:0]        run_len;
    logic [SEQ_WIDTH-1:0]    ack_val;

    assign busy   = (state_reg == ST_EXEC);
    assign accept = start && !busy;

    // Effective sequence width, modulus mask and window size.
    always_comb
    begin
        int ws;
        eff_bits = BW'(seq_bits_reg);
        if (eff_bits == '0)
        begin
            eff_bits = BW'(1);
        end
        if (int'(eff_bits) > SEQ_WIDTH)
        begin
            eff_bits = BW'(SEQ_WIDTH);
        end
        for (int i = 0; i < SEQ_WIDTH; i++)
        begin
            mmask[i] = (i < int'(eff_bits));
        end
        ws = int'(win_size_reg);
        if (ws < 1)
        begin
            ws = 1;
        end
        if (ws > WINDOW_DEPTH)
        begin
            ws = WINDOW_DEPTH;
        end
        // The modulus only limits the window when it is smaller than the depth.
        if (int'(eff_bits) < CNT_W && ws > (1 << eff_bits))
        begin
            ws = 1 << eff_bits;
        end
        eff_win = CNT_W'(ws);
    end

    assign base_cur = base_reg & mmask;

    // Execute cycle: apply the request to the valid bits and window registers.
    always_comb
    begin
        logic [SEQ_WIDTH-1:0] off;
        logic [HW:0]          slot_sum;
        logic [HW-1:0]        slot;
        logic [HW:0]          head_sum;
        logic                 in_win;

        valid_next     = valid_reg;
        head_next      = head_reg;
        base_next      = base_reg;
        complete_next  = complete_reg;
        stat_pend_next = stat_pend_reg;
        oh_pend_next   = oh_pend_reg;
        mem_we         = 1'b0;

        off      = (seq_reg - base_cur) & mmask;
        in_win   = ((seq_reg & ~mmask) == '0) && (AW'(off) < AW'(eff_win));
        slot_sum = (HW+1)'(head_reg) + (HW+1)'(off);
        if (slot_sum >= (HW+1)'(WINDOW_DEPTH))
        begin
            slot_sum = slot_sum - (HW+1)'(WINDOW_DEPTH);
        end
        slot     = slot_sum[HW-1:0];
        head_sum = (HW+1)'(head_reg) + (HW+1)'(1);
        if (head_sum >= (HW+1)'(WINDOW_DEPTH))
        begin
            head_sum = head_sum - (HW+1)'(WINDOW_DEPTH);
        end
        mem_addr = slot;

        if (state_reg == ST_EXEC)
        begin
            oh_pend_next = '0;
            unique case (req_reg)
                REQ_ARRIVE:
                begin
                    if (!in_win)
                    begin
                        stat_pend_next = STAT_OUT_OF_WIN;
                    end
                    else if (valid_reg[slot])
                    begin
                        stat_pend_next = STAT_DUPLICATE;
                    end
                    else
                    begin
                        valid_next[slot] = 1'b1;
                        mem_we           = 1'b1;
                        stat_pend_next   = STAT_STORED;
                    end
                end
                REQ_TAKE:
                begin
                    if (!valid_reg[head_reg])
                    begin
                        stat_pend_next = STAT_NONE_READY;
                    end
                    else
                    begin
                        oh_pend_next         = mem_rd_reg;
                        valid_next[head_reg] = 1'b0;
                        head_next            = head_sum[HW-1:0];
                        base_next            = (base_cur + SEQ_WIDTH'(1)) & mmask;
                        if (len_reg < full_len_reg)
                        begin
                            complete_next = 1'b1;
                        end
                        stat_pend_next = STAT_DELIVERED;
                    end
                end
                REQ_ACK:
                begin
                    stat_pend_next = STAT_ACK;
                end
                REQ_RESTART:
                begin
                    valid_next     = '0;
                    head_next      = '0;
                    base_next      = '0;
                    complete_next  = 1'b0;
                    stat_pend_next = STAT_RESTARTED;
                end
                default:
                begin
                    stat_pend_next = STAT_OUT_OF_WIN;
                end
            endcase
        end
    end

    // Count cycle: rotate the valid bits to the head, keep the window, and
    // count the run of received slots. The +1 turns the run into a carry
    // chain so the run itself can be isolated and counted.
    always_comb
    begin
        logic [WINDOW_DEPTH-1:0] run_bits;
        logic [WINDOW_DEPTH-1:0] ones;
        logic [HW:0]             idx;
        logic [AW-1:0]           ack_sum;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            idx = (HW+1)'(head_reg) + (HW+1)'(i);
            if (idx >= (HW+1)'(WINDOW_DEPTH))
            begin
                idx = idx - (HW+1)'(WINDOW_DEPTH);
            end
            run_bits[i] = valid_reg[idx[HW-1:0]] && (i < int'(eff_win));
        end
        ones    = run_bits & ~(run_bits + WINDOW_DEPTH'(1));
        run_len = CNT_W'($countones(ones));
        ack_sum = AW'(base_cur) + AW'(run_len) - AW'(1);
        ack_val = SEQ_WIDTH'(ack_sum) & mmask;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                state_next = accept ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and window state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seq_bits_reg  <= SEQ_BITS_RESET;
            win_size_reg  <= WIN_SIZE_RESET;
            full_len_reg  <= FULL_LEN_RESET;
            base_reg      <= '0;
            head_reg      <= '0;
            valid_reg     <= '0;
            complete_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            head_reg      <= head_next;
            valid_reg     <= valid_next;
            complete_reg  <= complete_next;
            res_valid_reg <= (state_reg == ST_COUNT);
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_SEQ_BITS:    seq_bits_reg <= cfg_data[SEQ_BITS_W-1:0];
                    CFG_WINDOW_SIZE: win_size_reg <= cfg_data[WIN_SIZE_W-1:0];
                    CFG_FULL_LEN:    full_len_reg <= cfg_data[FULL_LEN_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_type;
            seq_reg    <= seq_num;
            handle_reg <= payload_handle;
            len_reg    <= chunk_length;
        end
        stat_pend_reg <= stat_pend_next;
        oh_pend_reg   <= oh_pend_next;
        if (state_reg == ST_COUNT)
        begin
            status_reg     <= stat_pend_reg;
            out_handle_reg <= oh_pend_reg;
            ack_reg        <= (stat_pend_reg == STAT_ACK) ? ack_val : '0;
            ready_reg      <= run_len;
            done_reg       <= complete_reg;
        end
    end

    // Handle memory. Writes happen only in the execute cycle and reads only at
    // acceptance, so the two never touch the memory in the same cycle and the
    // head read always sees the latest stored handle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            handle_mem[mem_addr] <= handle_reg;
        end
        if (accept)
        begin
            mem_rd_reg <= handle_mem[head_reg];
        end
    end

    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign out_handle   = out_handle_reg;
    assign ack_num      = ack_reg;
    assign ready_count  = ready_reg;
    assign done_flag    = done_reg;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for selective_repeat_receive_window: drives requests and
// register writes, predicts every result and compares it field by field.
// Depends on srrw_pkg and the selective_repeat_receive_window RTL.

module testbench;
    import srrw_pkg::*;

    localparam int DEPTH = 32;
    localparam int PHASES = 8;
    localparam int PHASE_REQUESTS = 235;

    // Register settings for the random phases. Each phase writes all three
    // registers. Out-of-range and wide values are included on purpose: the
    // block keeps only the low bits, then clamps the sequence width to 1..16
    // and the window to the slot count and the modulus.
    localparam logic [15:0] SEQ_BITS_PLAN [PHASES] =
        '{16'd0, 16'd4, 16'd16, 16'hFFE5, 16'd31, 16'd3, 16'd12, 16'd8};
    localparam logic [15:0] WIN_SIZE_PLAN [PHASES] =
        '{16'd63, 16'd0, 16'd32, 16'd32, 16'd1, 16'd8, 16'hFFD7, 16'd32};
    localparam logic [15:0] FULL_LEN_PLAN [PHASES] =
        '{16'd0, 16'hFFFF, 16'd5120, 16'd1, 16'd40000, 16'd300, 16'h8001, 16'd5120};

    // One pending request, with the idle gap the driver leaves after it.
    typedef struct packed {
        req_t        kind;
        logic [15:0] seq;
        logic [15:0] handle;
        logic [15:0] len;
        logic [2:0]  gap;
    } request_s;

    // One predicted result.
    typedef struct packed {
        status_t     st;
        logic [15:0] handle;
        logic [15:0] ack;
        logic [5:0]  ready;
        logic        done;
    } outcome_s;

    // Block ports.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    cfg_index_t  cfg_index = CFG_SEQ_BITS;
    logic [15:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    req_t        req_type = REQ_ACK;
    logic [15:0] seq_num = '0;
    logic [15:0] payload_handle = '0;
    logic [15:0] chunk_length = '0;
    logic        result_valid;
    status_t     status;
    logic [15:0] out_handle;
    logic [15:0] ack_num;
    logic [5:0]  ready_count;
    logic        done_flag;

    // Stimulus bookkeeping.
    request_s    pending_requests[$];
    outcome_s    expected_results[$];
    request_s    next_req;
    outcome_s    oldest_result;
    int unsigned issued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned failures = 0;
    int unsigned hold_off = 0;
    logic [2:0]  driven_gap = '0;
    bit          steady_run = 1'b0;

    // Predicted state of the window and copies of the registers.
    logic [4:0]  cfg_seq_bits;
    logic [5:0]  cfg_win_size;
    logic [15:0] cfg_full_len;
    logic [15:0] win_base;
    logic [4:0]  win_head;
    logic        slot_full [DEPTH];
    logic [15:0] slot_buf [DEPTH];
    logic        xfer_done;

    selective_repeat_receive_window dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .seq_num        (seq_num),
        .payload_handle (payload_handle),
        .chunk_length   (chunk_length),
        .result_valid   (result_valid),
        .status         (status),
        .out_handle     (out_handle),
        .ack_num        (ack_num),
        .ready_count    (ready_count),
        .done_flag      (done_flag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // The sequence space is 2^bits, with bits clamped to 1..16.
    function automatic int unsigned seq_modulus();
        int unsigned bits;
        bits = cfg_seq_bits;
        if (bits < 1) bits = 1;
        if (bits > 16) bits = 16;
        return 32'd1 << bits;
    endfunction

    // Slots in use: at least one, never more than the slot count or the modulus.
    function automatic int unsigned window_span();
        int unsigned w;
        w = cfg_win_size;
        if (w < 1) w = 1;
        if (w > DEPTH) w = DEPTH;
        if (w > seq_modulus()) w = seq_modulus();
        return w;
    endfunction

    // Number of received slots in a row starting at the head, within the window.
    function automatic int unsigned in_order_run(int unsigned w);
        int unsigned n;
        n = 0;
        while (n < w && slot_full[(win_head + n) % DEPTH]) n++;
        return n;
    endfunction

    // Reset and restart both empty the window; stored handles are left alone.
    function automatic void clear_window();
        win_base = '0;
        win_head = '0;
        xfer_done = 1'b0;
        for (int i = 0; i < DEPTH; i++) slot_full[i] = 1'b0;
    endfunction

    // Applies one accepted request to the predicted state and queues the result
    // the block must produce for it.
    function automatic void apply_request(req_t kind, logic [15:0] seq,
                                          logic [15:0] handle, logic [15:0] len);
        int unsigned m;
        int unsigned mask;
        int unsigned w;
        int unsigned base;
        int unsigned off;
        int unsigned slot;
        outcome_s res;
        m = seq_modulus();
        mask = m - 1;
        w = window_span();
        // A stored base may be wider than a newly narrowed sequence space.
        base = win_base & mask;
        res = '0;
        case (kind)
            REQ_ARRIVE:
            begin
                // The distance from the base wraps in the sequence space; numbers
                // at or above the modulus never fit.
                off = (seq + m - base) & mask;
                if (seq >= m || off >= w) begin
                    res.st = STAT_OUT_OF_WIN;
                end else begin
                    slot = (win_head + off) % DEPTH;
                    if (slot_full[slot]) begin
                        res.st = STAT_DUPLICATE;
                    end else begin
                        slot_full[slot] = 1'b1;
                        slot_buf[slot] = handle;
                        res.st = STAT_STORED;
                    end
                end
            end
            REQ_TAKE:
            begin
                if (!slot_full[win_head]) begin
                    // Nothing slides and the complete flag is kept.
                    res.st = STAT_NONE_READY;
                end else begin
                    res.handle = slot_buf[win_head];
                    slot_full[win_head] = 1'b0;
                    win_head = win_head + 5'd1;
                    win_base = 16'((base + 1) & mask);
                    if (len < cfg_full_len) xfer_done = 1'b1;
                    res.st = STAT_DELIVERED;
                end
            end
            REQ_ACK:
            begin
                // With nothing ready this wraps to one below the base.
                res.ack = 16'((base + in_order_run(w) + m - 1) & mask);
                res.st = STAT_ACK;
            end
            default:
            begin
                clear_window();
                res.st = STAT_RESTARTED;
            end
        endcase
        res.ready = 6'(in_order_run(w));
        res.done = xfer_done;
        expected_results = {expected_results, res};
    endfunction

    // ------------------------------------------------------------------
    // Driver: a request is taken at an edge where start is high and busy is
    // low. The prediction is made right there from the values on the ports.
    // After each request the driver keeps start low for that request's gap,
    // which makes start rise both during the busy cycle and later.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start <= 1'b0;
            hold_off = 0;
        end else begin
            if (start && !busy) begin
                apply_request(req_type, seq_num, payload_handle, chunk_length);
                accepted_count++;
                hold_off = driven_gap;
            end
            // While a request waits for busy to drop, everything is held.
            if (!start || !busy) begin
                if (hold_off != 0) begin
                    hold_off--;
                    start <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    next_req = pending_requests.pop_front();
                    start <= 1'b1;
                    req_type <= next_req.kind;
                    seq_num <= next_req.seq;
                    payload_handle <= next_req.handle;
                    chunk_length <= next_req.len;
                    driven_gap = next_req.gap;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: the receiver cannot stall, so every strobed result is taken at
    // once and matched against the oldest prediction.
    // ------------------------------------------------------------------
    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got status %0h",
                         $time, status);
                failures++;
            end else begin
                oldest_result = expected_results.pop_front();
                compare_field("status", oldest_result.st, status);
                compare_field("out_handle", oldest_result.handle, out_handle);
                compare_field("ack_num", oldest_result.ack, ack_num);
                compare_field("ready_count", oldest_result.ready, ready_count);
                compare_field("done_flag", oldest_result.done, done_flag);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Queues one request. The queue is kept short so that requests built from
    // the predicted window state are not far behind it.
    task automatic send(req_t kind, logic [15:0] seq, logic [15:0] handle,
                        logic [15:0] len);
        request_s r;
        while (pending_requests.size() > 1) @(negedge clk);
        r.kind = kind;
        r.seq = seq;
        r.handle = handle;
        r.len = len;
        r.gap = steady_run ? 3'd0 : 3'($urandom_range(0, 5));
        pending_requests = {pending_requests, r};
        issued_count++;
    endtask

    // Waits until every queued request is taken; with drain set, also until
    // every result has come back, and then lets the block settle.
    task automatic wait_idle(bit drain);
        while (accepted_count != issued_count
               || (drain && expected_results.size() != 0)) @(negedge clk);
        if (drain) repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SEQ_BITS:    cfg_seq_bits = data[4:0];
            CFG_WINDOW_SIZE: cfg_win_size = data[5:0];
            default:         cfg_full_len = data;
        endcase
    endtask

    // Lengths near the threshold decide whether a delivery completes the transfer.
    function automatic logic [15:0] chunk_len_pick();
        case ($urandom_range(0, 4))
            0:       return cfg_full_len - 16'd1;
            1:       return cfg_full_len;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One request of the noisy mix. Arrivals mostly land in the window, some
    // just past it or just behind the base, some anywhere in the 16-bit range.
    task automatic random_request();
        int unsigned m;
        int unsigned w;
        int unsigned roll;
        logic [15:0] seq;
        m = seq_modulus();
        w = window_span();
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: seq = 16'((win_base + $urandom_range(0, w - 1)) & (m - 1));
                4:          seq = 16'((win_base + w + $urandom_range(0, 1)) & (m - 1));
                5:          seq = 16'((win_base + m - 1 - $urandom_range(0, 1)) & (m - 1));
                default:    seq = 16'($urandom);
            endcase
            send(REQ_ARRIVE, seq, 16'($urandom), 16'($urandom));
        end else if (roll < 85) begin
            send(REQ_TAKE, 16'($urandom), 16'($urandom), chunk_len_pick());
        end else begin
            send(REQ_ACK, 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    // Random part of one phase. Most of it is well-formed transfers: the whole
    // window arrives in shuffled order, sometimes with holes and repeats, and
    // is then partly or fully drained by takes with acks in between. The rest
    // is the noisy mix and the odd restart.
    task automatic run_phase(int unsigned count);
        int unsigned first;
        int unsigned m;
        int unsigned w;
        int unsigned j;
        int unsigned k;
        int unsigned t;
        bit          holes;
        int unsigned order [DEPTH];
        first = issued_count;
        while (issued_count - first < count) begin
            if ($urandom_range(0, 7) == 0) steady_run = !steady_run;
            t = $urandom_range(0, 99);
            if (t < 45) begin
                // The base must be settled before the transfer is laid out.
                wait_idle(1'b0);
                m = seq_modulus();
                w = window_span();
                holes = $urandom_range(0, 1);
                for (j = 0; j < w; j++) order[j] = j;
                for (j = w - 1; j > 0; j--) begin
                    k = $urandom_range(0, j);
                    t = order[j];
                    order[j] = order[k];
                    order[k] = t;
                end
                for (j = 0; j < w; j++) begin
                    if (!(holes && $urandom_range(0, 7) == 0)) begin
                        send(REQ_ARRIVE, 16'((win_base + order[j]) & (m - 1)),
                             16'($urandom), 16'($urandom));
                        if ($urandom_range(0, 9) == 0)
                            send(REQ_ARRIVE, 16'((win_base + order[j]) & (m - 1)),
                                 16'($urandom), 16'($urandom));
                    end
                end
                send(REQ_ACK, 16'($urandom), 16'($urandom), 16'($urandom));
                repeat ($urandom_range(1, w + 1)) begin
                    send(REQ_TAKE, 16'($urandom), 16'($urandom), chunk_len_pick());
                    if ($urandom_range(0, 3) == 0)
                        send(REQ_ACK, 16'($urandom), 16'($urandom), 16'($urandom));
                end
            end else if (t < 97) begin
                repeat ($urandom_range(8, 20)) random_request();
            end else begin
                send(REQ_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial
    begin
        cfg_seq_bits = SEQ_BITS_RESET;
        cfg_win_size = WIN_SIZE_RESET;
        cfg_full_len = FULL_LEN_RESET;
        clear_window();
        for (int i = 0; i < DEPTH; i++) slot_buf[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings: 256 sequence numbers, 32 slots,
        // full chunk length 5120.
        send(REQ_ACK, 16'h0000, 16'h0000, 16'h0000);       // nothing ready, wraps below base
        send(REQ_TAKE, 16'h0000, 16'h0000, 16'h0000);      // take with an empty head
        send(REQ_ARRIVE, 16'd0, 16'hFFFF, 16'hFFFF);       // stored at the head
        send(REQ_ARRIVE, 16'd0, 16'h1234, 16'h0000);       // duplicate
        send(REQ_ARRIVE, 16'd31, 16'h0000, 16'h0000);      // last slot of the window
        send(REQ_ARRIVE, 16'd32, 16'h5A5A, 16'h0000);      // one past the window
        send(REQ_ARRIVE, 16'd255, 16'h5A5A, 16'h0000);     // just behind the base
        send(REQ_ARRIVE, 16'd256, 16'h5A5A, 16'h0000);     // equal to the modulus
        send(REQ_ARRIVE, 16'hFFFF, 16'h5A5A, 16'h0000);    // largest sequence number
        send(REQ_ACK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(REQ_TAKE, 16'h0000, 16'h0000, 16'hFFFF);      // full chunk, not complete
        send(REQ_ARRIVE, 16'd1, 16'hA5A5, 16'h0000);
        send(REQ_TAKE, 16'h0000, 16'h0000, 16'd5119);      // short chunk completes
        send(REQ_TAKE, 16'h0000, 16'h0000, 16'h0000);      // empty head keeps the flag
        send(REQ_ACK, 16'h0000, 16'h0000, 16'h0000);
        send(REQ_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(REQ_ACK, 16'h0000, 16'h0000, 16'h0000);       // back to the wrapped ack
        wait_idle(1'b1);

        // Random phases. The window is not restarted between phases, so each
        // register change also lands in the middle of a transfer.
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_SEQ_BITS, SEQ_BITS_PLAN[p]);
            write_reg(CFG_WINDOW_SIZE, WIN_SIZE_PLAN[p]);
            write_reg(CFG_FULL_LEN, FULL_LEN_PLAN[p]);
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            run_phase(PHASE_REQUESTS);
            wait_idle(1'b1);
        end

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // A correct run needs well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/srrw_pkg.sv
rtl/selective_repeat_receive_window.sv
verif/testbench.sv
